// File: hw/rtl/obtob_pkg.sv
// Package for the order book top-of-book unit: request/response payload
// types, controller states, control/status structs and shared constants.
// No dependencies.
`default_nettype none

package obtob_pkg;

    // Field widths fixed by the payload format
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;

    // Default number of price levels per book side
    localparam int LEVELS_DEF = 64;

    // Book side codes
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    // One level update request
    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
        logic               end_of_message;
    } obtob_req_t;

    // Top-of-book report
    typedef struct packed {
        logic [PRICE_W-1:0] best_bid_price;
        logic [QTY_W-1:0]   best_bid_quantity;
        logic [PRICE_W-1:0] best_ask_price;
        logic [QTY_W-1:0]   best_ask_quantity;
        logic               overflowed;
    } obtob_rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } obtob_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic clear_en;
        logic load_item;
        logic scan_en;
        logic apply_en;
    } obtob_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic clear_last;
        logic scan_done;
        logic item_eom;
        logic rsp_full;
    } obtob_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/obtob_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on obtob_pkg for default sizes.
`default_nettype none

module obtob_ram #(
    parameter int WIDTH = obtob_pkg::PRICE_W,
    parameter int DEPTH = obtob_pkg::LEVELS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/obtob_ctrl.sv
// Controller FSM for the top-of-book unit: clearing pass, request intake,
// table scan and apply/report sequencing. Depends on obtob_pkg.
`default_nettype none

module obtob_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    req_valid,
    output logic                         req_ready,
    input  wire obtob_pkg::obtob_status_t status,
    output obtob_pkg::obtob_cmd_t        cmd
);

    obtob_pkg::obtob_state_t state_reg;
    obtob_pkg::obtob_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obtob_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            obtob_pkg::ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = obtob_pkg::ST_IDLE;
                end
            end
            obtob_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = obtob_pkg::ST_SCAN;
                end
            end
            obtob_pkg::ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = obtob_pkg::ST_APPLY;
                end
            end
            obtob_pkg::ST_APPLY:
            begin
                // a report waits for the response register to drain
                if (!(status.item_eom && status.rsp_full))
                begin
                    cmd.apply_en = 1'b1;
                    state_next   = obtob_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = obtob_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/obtob_dp.sv
// Datapath for the top-of-book unit: level tables in RAM, scan for match,
// free slot and best levels, table update and response register.
// Depends on obtob_pkg and obtob_ram.
`default_nettype none

module obtob_dp #(
    parameter int LEVELS = obtob_pkg::LEVELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire obtob_pkg::obtob_req_t req,
    input  wire obtob_pkg::obtob_cmd_t cmd,
    output obtob_pkg::obtob_status_t   status,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output obtob_pkg::obtob_rsp_t      rsp
);

    localparam int IDX_W = $clog2(LEVELS);
    localparam int CNT_W = $clog2(LEVELS + 1);
    localparam int PW    = obtob_pkg::PRICE_W;
    localparam int QW    = obtob_pkg::QTY_W;

    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(LEVELS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LEVELS - 1);

    // Captured request and scan control
    obtob_pkg::obtob_req_t item_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg;

    // Scan results
    logic             match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_idx_reg, match_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             bid_found_reg, bid_found_next;
    logic [PW-1:0]    bid_price_reg, bid_price_next;
    logic [QW-1:0]    bid_qty_reg, bid_qty_next;
    logic             ask_found_reg, ask_found_next;
    logic [PW-1:0]    ask_price_reg, ask_price_next;
    logic [QW-1:0]    ask_qty_reg, ask_qty_next;

    // Overflow and response
    logic                  sticky_reg, sticky_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    obtob_pkg::obtob_rsp_t rsp_reg;

    // RAM ports: price RAMs hold {used, price}
    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic [PW:0]      pr_wdata;
    logic             bid_pr_we, ask_pr_we, bid_qty_we, ask_qty_we;
    logic [PW:0]      bid_pr_rd, ask_pr_rd;
    logic [QW-1:0]    bid_qty_rd, ask_qty_rd;

    // Scan evaluation
    logic          is_bid;
    logic          qty_zero;
    logic          bid_used, bid_hit, bid_cand;
    logic [QW-1:0] bid_cq;
    logic          ask_used, ask_hit, ask_cand;
    logic [QW-1:0] ask_cq;
    logic          sel_used, sel_hit;

    // Apply decisions
    logic          do_remove, do_replace, do_insert, do_drop;
    logic [IDX_W-1:0] apply_idx;
    logic [PW-1:0] fin_bid_price, fin_ask_price;
    logic [QW-1:0] fin_bid_qty, fin_ask_qty;

    assign raddr = cnt_reg[IDX_W-1:0];

    // Level tables
    obtob_ram #(.WIDTH(PW + 1), .DEPTH(LEVELS)) u_bid_pr (
        .clk   (clk),
        .we    (bid_pr_we),
        .waddr (waddr),
        .wdata (pr_wdata),
        .raddr (raddr),
        .rdata (bid_pr_rd)
    );

    obtob_ram #(.WIDTH(QW), .DEPTH(LEVELS)) u_bid_qty (
        .clk   (clk),
        .we    (bid_qty_we),
        .waddr (waddr),
        .wdata (item_reg.quantity),
        .raddr (raddr),
        .rdata (bid_qty_rd)
    );

    obtob_ram #(.WIDTH(PW + 1), .DEPTH(LEVELS)) u_ask_pr (
        .clk   (clk),
        .we    (ask_pr_we),
        .waddr (waddr),
        .wdata (pr_wdata),
        .raddr (raddr),
        .rdata (ask_pr_rd)
    );

    obtob_ram #(.WIDTH(QW), .DEPTH(LEVELS)) u_ask_qty (
        .clk   (clk),
        .we    (ask_qty_we),
        .waddr (waddr),
        .wdata (item_reg.quantity),
        .raddr (raddr),
        .rdata (ask_qty_rd)
    );

    // Apply decisions from the scan result
    assign is_bid     = (item_reg.side == obtob_pkg::SIDE_BID);
    assign qty_zero   = (item_reg.quantity == '0);
    assign do_remove  = qty_zero && match_found_reg;
    assign do_replace = !qty_zero && match_found_reg;
    assign do_insert  = !qty_zero && !match_found_reg && free_found_reg;
    assign do_drop    = !qty_zero && !match_found_reg && !free_found_reg;
    assign apply_idx  = do_insert ? free_idx_reg : match_idx_reg;

    // Write port: clearing pass or table update
    always_comb
    begin
        if (cmd.clear_en)
        begin
            waddr      = raddr;
            pr_wdata   = '0;
            bid_pr_we  = 1'b1;
            ask_pr_we  = 1'b1;
            bid_qty_we = 1'b0;
            ask_qty_we = 1'b0;
        end
        else
        begin
            waddr      = apply_idx;
            pr_wdata   = {do_insert, item_reg.price};
            bid_pr_we  = cmd.apply_en && is_bid && (do_remove || do_insert);
            ask_pr_we  = cmd.apply_en && !is_bid && (do_remove || do_insert);
            bid_qty_we = cmd.apply_en && is_bid && (do_replace || do_insert);
            ask_qty_we = cmd.apply_en && !is_bid && (do_replace || do_insert);
        end
    end

    // Per-entry evaluation; the updated side sees the pending change
    always_comb
    begin
        bid_used = bid_pr_rd[PW];
        bid_hit  = bid_used && (bid_pr_rd[PW-1:0] == item_reg.price);
        bid_cand = bid_used && !(is_bid && bid_hit && qty_zero);
        bid_cq   = (is_bid && bid_hit) ? item_reg.quantity : bid_qty_rd;
        ask_used = ask_pr_rd[PW];
        ask_hit  = ask_used && (ask_pr_rd[PW-1:0] == item_reg.price);
        ask_cand = ask_used && !(!is_bid && ask_hit && qty_zero);
        ask_cq   = (!is_bid && ask_hit) ? item_reg.quantity : ask_qty_rd;
        sel_used = is_bid ? bid_used : ask_used;
        sel_hit  = is_bid ? bid_hit : ask_hit;
    end

    // Scan counter and result accumulation
    always_comb
    begin
        cnt_next         = cnt_reg;
        rd_valid_next    = 1'b0;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        bid_found_next   = bid_found_reg;
        bid_price_next   = bid_price_reg;
        bid_qty_next     = bid_qty_reg;
        ask_found_next   = ask_found_reg;
        ask_price_next   = ask_price_reg;
        ask_qty_next     = ask_qty_reg;

        if (cmd.load_item)
        begin
            cnt_next         = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
            bid_found_next   = 1'b0;
            bid_price_next   = '0;
            bid_qty_next     = '0;
            ask_found_next   = 1'b0;
            ask_price_next   = '0;
            ask_qty_next     = '0;
        end
        else
        begin
            if (cmd.clear_en || (cmd.scan_en && (cnt_reg < CNT_END)))
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            rd_valid_next = cmd.scan_en && (cnt_reg < CNT_END);

            if (rd_valid_reg)
            begin
                if (sel_hit && !match_found_reg)
                begin
                    match_found_next = 1'b1;
                    match_idx_next   = rd_idx_reg;
                end
                if (!sel_used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = rd_idx_reg;
                end
                if (bid_cand && (!bid_found_reg || (bid_pr_rd[PW-1:0] > bid_price_reg)))
                begin
                    bid_found_next = 1'b1;
                    bid_price_next = bid_pr_rd[PW-1:0];
                    bid_qty_next   = bid_cq;
                end
                if (ask_cand && (!ask_found_reg || (ask_pr_rd[PW-1:0] < ask_price_reg)))
                begin
                    ask_found_next = 1'b1;
                    ask_price_next = ask_pr_rd[PW-1:0];
                    ask_qty_next   = ask_cq;
                end
            end
        end
    end

    // Final best levels, counting a newly inserted level
    always_comb
    begin
        fin_bid_price = bid_price_reg;
        fin_bid_qty   = bid_qty_reg;
        fin_ask_price = ask_price_reg;
        fin_ask_qty   = ask_qty_reg;
        if (do_insert && is_bid && (!bid_found_reg || (item_reg.price > bid_price_reg)))
        begin
            fin_bid_price = item_reg.price;
            fin_bid_qty   = item_reg.quantity;
        end
        if (do_insert && !is_bid && (!ask_found_reg || (item_reg.price < ask_price_reg)))
        begin
            fin_ask_price = item_reg.price;
            fin_ask_qty   = item_reg.quantity;
        end
    end

    // Sticky overflow and response handshake
    always_comb
    begin
        sticky_next = sticky_reg;
        if (cmd.apply_en)
        begin
            sticky_next = item_reg.end_of_message ? 1'b0 : (sticky_reg || do_drop);
        end
        rsp_valid_next = (rsp_valid_reg && !rsp_ready)
                         || (cmd.apply_en && item_reg.end_of_message);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            sticky_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_valid_reg  <= rd_valid_next;
            sticky_reg    <= sticky_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        rd_idx_reg      <= raddr;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        bid_found_reg   <= bid_found_next;
        bid_price_reg   <= bid_price_next;
        bid_qty_reg     <= bid_qty_next;
        ask_found_reg   <= ask_found_next;
        ask_price_reg   <= ask_price_next;
        ask_qty_reg     <= ask_qty_next;
        if (cmd.apply_en && item_reg.end_of_message)
        begin
            rsp_reg.best_bid_price    <= fin_bid_price;
            rsp_reg.best_bid_quantity <= fin_bid_qty;
            rsp_reg.best_ask_price    <= fin_ask_price;
            rsp_reg.best_ask_quantity <= fin_ask_qty;
            rsp_reg.overflowed        <= sticky_reg || do_drop;
        end
    end

    // Status to controller
    always_comb
    begin
        status.clear_last = (cnt_reg == CNT_LAST);
        status.scan_done  = (cnt_reg == CNT_END);
        status.item_eom   = item_reg.end_of_message;
        status.rsp_full   = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: hw/rtl/order_book_top_of_book_unit.sv
// Order book top-of-book unit: bid and ask price-level tables with best-level report.
// Each request passes through intake, a scan of both tables through one RAM read port
// each and an apply step; a new request is accepted only once the previous one is
// applied. The apply step of an end-of-message request registers the report, waiting
// while an earlier report is held. After reset a clearing pass over every level runs
// before the first request. Depends on obtob_pkg, obtob_ctrl, obtob_dp and obtob_ram.
`default_nettype none

module order_book_top_of_book_unit #(
    parameter int LEVELS = obtob_pkg::LEVELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire obtob_pkg::obtob_req_t req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output obtob_pkg::obtob_rsp_t      rsp
);

    obtob_pkg::obtob_cmd_t    cmd;
    obtob_pkg::obtob_status_t status;

    // Sequencer
    obtob_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Tables, scan and response
    obtob_dp #(.LEVELS(LEVELS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: verif/tb_order_book_top_of_book_unit.sv
// Self-checking testbench for order_book_top_of_book_unit: drives level update requests
// and checks every top-of-book report against an in-bench price-level predictor.
// Depends on obtob_pkg and the order_book_top_of_book_unit RTL.
`timescale 1ns / 100ps

module tb_order_book_top_of_book_unit;

    localparam int LEVELS         = obtob_pkg::LEVELS_DEF;
    localparam int TARGET_UPDATES = 1650;

    typedef struct {
        obtob_pkg::obtob_req_t upd;
        bit                    drain_first;
    } queued_update_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    obtob_pkg::obtob_req_t req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    obtob_pkg::obtob_rsp_t rsp;

    order_book_top_of_book_unit #(
        .LEVELS(LEVELS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #1 clk = ~clk;

    // Pending requests and expected reports
    queued_update_t        update_queue[$];
    obtob_pkg::obtob_rsp_t expected_reports[$];

    // Prices the generator believes are live on each side (0 bid, 1 ask)
    logic [31:0] live_prices[2][$];

    // Predicted book
    logic [31:0] level_price[2][LEVELS];
    logic [31:0] level_qty[2][LEVELS];
    bit          level_used[2][LEVELS];
    bit          drop_sticky = 1'b0;

    int error_count    = 0;
    int accepted_count = 0;
    int total_updates  = 0;
    int req_gap        = 0;
    int rsp_stall      = 0;
    int calm_items     = 0;
    bit req_fire       = 1'b0;
    bit rsp_fire       = 1'b0;
    bit stall_drawn    = 1'b0;
    bit drain_next     = 1'b0;

    task automatic report_mismatch(string what);
        error_count++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // Apply one level update to the predicted book; queue a report on end of message
    function automatic void book_apply_update(obtob_pkg::obtob_req_t u);
        int                    si;
        int                    hit;
        int                    slot;
        bit                    found;
        obtob_pkg::obtob_rsp_t rpt;
        si   = (u.side == obtob_pkg::SIDE_ASK) ? 1 : 0;
        hit  = -1;
        slot = -1;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (level_used[si][i])
            begin
                if (level_price[si][i] == u.price && hit < 0)
                    hit = i;
            end
            else if (slot < 0)
            begin
                slot = i;
            end
        end
        if (u.quantity == '0)
        begin
            if (hit >= 0)
                level_used[si][hit] = 1'b0;
        end
        else if (hit >= 0)
        begin
            level_qty[si][hit] = u.quantity;
        end
        else if (slot >= 0)
        begin
            level_price[si][slot] = u.price;
            level_qty[si][slot]   = u.quantity;
            level_used[si][slot]  = 1'b1;
        end
        else
        begin
            drop_sticky = 1'b1;
        end
        if (!u.end_of_message)
            return;
        rpt   = '0;
        found = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (level_used[0][i] && (!found || level_price[0][i] > rpt.best_bid_price))
            begin
                rpt.best_bid_price    = level_price[0][i];
                rpt.best_bid_quantity = level_qty[0][i];
                found = 1'b1;
            end
        end
        found = 1'b0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (level_used[1][i] && (!found || level_price[1][i] < rpt.best_ask_price))
            begin
                rpt.best_ask_price    = level_price[1][i];
                rpt.best_ask_quantity = level_qty[1][i];
                found = 1'b1;
            end
        end
        rpt.overflowed = drop_sticky;
        drop_sticky    = 1'b0;
        expected_reports.push_back(rpt);
    endfunction

    task automatic check_report(obtob_pkg::obtob_rsp_t got);
        obtob_pkg::obtob_rsp_t want;
        if (expected_reports.size() == 0)
        begin
            report_mismatch($sformatf("report with none expected: %h", got));
            return;
        end
        want = expected_reports.pop_front();
        if (got.best_bid_price !== want.best_bid_price)
            report_mismatch($sformatf("best_bid_price got %h want %h",
                                      got.best_bid_price, want.best_bid_price));
        if (got.best_bid_quantity !== want.best_bid_quantity)
            report_mismatch($sformatf("best_bid_quantity got %h want %h",
                                      got.best_bid_quantity, want.best_bid_quantity));
        if (got.best_ask_price !== want.best_ask_price)
            report_mismatch($sformatf("best_ask_price got %h want %h",
                                      got.best_ask_price, want.best_ask_price));
        if (got.best_ask_quantity !== want.best_ask_quantity)
            report_mismatch($sformatf("best_ask_quantity got %h want %h",
                                      got.best_ask_quantity, want.best_ask_quantity));
        if (got.overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %b want %b",
                                      got.overflowed, want.overflowed));
    endtask

    // Idle cycles before the next request or response; zero inside a calm stretch
    function automatic int draw_gap();
        if (calm_items > 0)
            return 0;
        return $urandom_range(0, 8);
    endfunction

    function automatic int find_live(int si, logic [31:0] p);
        for (int i = 0; i < live_prices[si].size(); i++)
            if (live_prices[si][i] == p)
                return i;
        return -1;
    endfunction

    // Queue one request and track which prices it leaves live
    function automatic void add_level(logic s, logic [31:0] p, logic [31:0] q, logic eom);
        queued_update_t item;
        int             si;
        int             k;
        si                       = (s == obtob_pkg::SIDE_ASK) ? 1 : 0;
        item.upd.side            = s;
        item.upd.price           = p;
        item.upd.quantity        = q;
        item.upd.end_of_message  = eom;
        item.drain_first         = drain_next;
        drain_next               = 1'b0;
        update_queue.push_back(item);
        total_updates++;
        k = find_live(si, p);
        if (q == '0)
        begin
            if (k >= 0)
                live_prices[si].delete(k);
        end
        else if (k < 0 && live_prices[si].size() < LEVELS)
        begin
            live_prices[si].push_back(p);
        end
    endfunction

    // Price not live on that side: either anywhere or in a crowded band
    function automatic logic [31:0] fresh_price(int si);
        logic [31:0] p;
        p = ($urandom_range(0, 1) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 300);
        while (find_live(si, p) >= 0)
            p = p + 1;
        return p;
    endfunction

    function automatic logic [31:0] random_qty();
        logic [31:0] q;
        case ($urandom_range(0, 9))
            0:       q = '1;
            1, 2:    q = $urandom_range(1, 20);
            default: q = $urandom;
        endcase
        if (q == '0)
            q = 32'd1;
        return q;
    endfunction

    // Stimulus, reset and end of run
    initial
    begin
        int          kind;
        int          n;
        int          si;
        int          op;
        int          msg_count;
        logic        s;
        logic [31:0] p;

        // Empty book, price zero, price and quantity extremes, replace and remove
        add_level(obtob_pkg::SIDE_BID, 32'd5, '0, 1'b1);
        add_level(obtob_pkg::SIDE_BID, '0, 32'd1, 1'b1);
        add_level(obtob_pkg::SIDE_BID, '1, '1, 1'b0);
        add_level(obtob_pkg::SIDE_ASK, '1, 32'd7, 1'b0);
        add_level(obtob_pkg::SIDE_ASK, '0, '1, 1'b1);
        add_level(obtob_pkg::SIDE_BID, '1, 32'h5555_5555, 1'b0);
        add_level(obtob_pkg::SIDE_ASK, '0, 32'hAAAA_AAAA, 1'b1);
        add_level(obtob_pkg::SIDE_ASK, 32'd5, '0, 1'b1);
        add_level(obtob_pkg::SIDE_BID, '1, '0, 1'b1);
        add_level(obtob_pkg::SIDE_ASK, '0, '0, 1'b0);
        add_level(obtob_pkg::SIDE_ASK, '1, '0, 1'b1);
        add_level(obtob_pkg::SIDE_BID, '0, '0, 1'b1);

        // Random messages; the first one overfills the table of one side
        msg_count = 0;
        while (total_updates < TARGET_UPDATES)
        begin
            if (msg_count % 40 == 0)
                drain_next = 1'b1;
            kind = (msg_count == 0) ? 0 : $urandom_range(0, 99);
            s    = ($urandom_range(0, 1) == 0) ? obtob_pkg::SIDE_BID : obtob_pkg::SIDE_ASK;
            si   = (s == obtob_pkg::SIDE_ASK) ? 1 : 0;
            if (kind < 8)
            begin
                // snapshot-sized burst of new levels, often past capacity
                n = (msg_count == 0) ? LEVELS + 6 : $urandom_range(30, 75);
                for (int j = 0; j < n; j++)
                    add_level(s, fresh_price(si), random_qty(), j == n - 1);
            end
            else if (kind < 16)
            begin
                // wipe one side
                n = live_prices[si].size();
                if (n == 0)
                    add_level(s, fresh_price(si), '0, 1'b1);
                for (int j = 0; j < n; j++)
                    add_level(s, live_prices[si][0], '0, j == n - 1);
            end
            else
            begin
                n = $urandom_range(1, 5);
                for (int j = 0; j < n; j++)
                begin
                    op = $urandom_range(0, 99);
                    s  = ($urandom_range(0, 1) == 0) ? obtob_pkg::SIDE_BID : obtob_pkg::SIDE_ASK;
                    si = (s == obtob_pkg::SIDE_ASK) ? 1 : 0;
                    if (op < 30 && live_prices[si].size() > 0)
                    begin
                        p = live_prices[si][$urandom_range(0, live_prices[si].size() - 1)];
                        add_level(s, p, random_qty(), j == n - 1);
                    end
                    else if (op < 55 && live_prices[si].size() > 0)
                    begin
                        p = live_prices[si][$urandom_range(0, live_prices[si].size() - 1)];
                        add_level(s, p, '0, j == n - 1);
                    end
                    else if (op < 60)
                        add_level(s, fresh_price(si), '0, j == n - 1);
                    else if (op < 90)
                        add_level(s, fresh_price(si), random_qty(), j == n - 1);
                    else
                        add_level(s, $urandom,
                                  ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom,
                                  j == n - 1);
                end
            end
            msg_count++;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (accepted_count < total_updates || expected_reports.size() > 0)
            @(negedge clk);
        repeat (LEVELS + 16) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Timeout
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Request driver: holds each request until accepted, then waits its gap
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_fire)
        begin
            if (req_gap > 0)
            begin
                req_valid <= 1'b0;
                req_gap = req_gap - 1;
            end
            else if (update_queue.size() > 0 &&
                     !(update_queue[0].drain_first && expected_reports.size() > 0))
            begin
                req       <= update_queue[0].upd;
                req_valid <= 1'b1;
                update_queue.delete(0);
                req_gap = draw_gap();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Report sink: stalls a random number of cycles on each report
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_fire)
                stall_drawn = 1'b0;
            if (rsp_valid && !stall_drawn)
            begin
                rsp_stall   = draw_gap();
                stall_drawn = 1'b1;
            end
            if (rsp_stall > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_stall = rsp_stall - 1;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Monitor: check reports first, then predict for the accepted request
    always @(posedge clk)
    begin
        req_fire = 1'b0;
        rsp_fire = 1'b0;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_fire = 1'b1;
                check_report(rsp);
            end
            if (req_valid && req_ready)
            begin
                req_fire = 1'b1;
                accepted_count++;
                book_apply_update(req);
                if (calm_items > 0)
                    calm_items--;
                else if ($urandom_range(0, 49) == 0)
                    calm_items = $urandom_range(20, 60);
            end
        end
    end

endmodule

// File: filelist.f
hw/rtl/obtob_pkg.sv
hw/rtl/obtob_ram.sv
hw/rtl/obtob_ctrl.sv
hw/rtl/obtob_dp.sv
hw/rtl/order_book_top_of_book_unit.sv
verif/tb_order_book_top_of_book_unit.sv
